// File: hdl/fpam_pkg.sv
// Shared types and codes for the flash page allocation map.
package fpam_pkg;

    typedef enum logic [2:0] {
        OP_FIND  = 3'd0,
        OP_USE   = 3'd1,
        OP_FREE  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_FLUSH = 3'd4,
        OP_LOAD  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    localparam logic [1:0]  PS_FREE   = 2'b11;
    localparam logic [1:0]  PS_USED   = 2'b10;
    localparam logic [7:0]  GROUP_FREE = 8'hFF;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the input item
        logic addr_clear;  // restart the sweep/scan address
        logic sweep_step;  // write a free group, advance
        logic scan_step;   // issue one group read, check the previous one
        logic rmw_write;   // write back the modified group
        logic post;        // finish the item into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic in_range;
        logic sweep_last;
        logic scan_empty;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

// File: hdl/fpam_ctrl.sv
// Sequencing state machine of the flash page allocation map.
module fpam_ctrl import fpam_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.addr_clear = 1'b1;
                case (status.op)
                    OP_FIND: begin
                        state_next = status.scan_empty ? ST_DONE : ST_SCAN;
                    end
                    OP_USE, OP_FREE: begin
                        state_next = status.in_range ? ST_RMW_RD : ST_DONE;
                    end
                    OP_CLEAR: begin
                        state_next = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit || status.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_RMW_RD: begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                cmd.rmw_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the item
                if (status.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// File: hdl/fpam_dp.sv
// Datapath of the flash page allocation map: state memory, counter, scan, result.
module fpam_dp import fpam_pkg::*; #(
    parameter int PAGES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic [2:0]  s_operation,
    input  logic [15:0] s_page,
    input  logic [7:0]  s_group_states,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_found,
    output logic [11:0] m_found_page,
    output logic        m_table_dirty
);

    localparam int GROUPS      = (PAGES + 3) / 4;
    localparam int FULL_GROUPS = PAGES / 4;
    localparam int AW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW          = $clog2(GROUPS + 1);
    localparam logic [16:0] PAGES_W  = 17'(PAGES);
    localparam logic [16:0] FULL_W   = 17'(FULL_GROUPS);
    localparam logic [CW-1:0] LAST_G = CW'(GROUPS - 1);

    logic [7:0] mem [0:GROUPS-1];

    op_t         op_reg;
    logic [15:0] page_reg;
    logic [7:0]  grp_reg;
    logic [15:0] spc_reg;
    logic [15:0] count_reg;
    logic [CW-1:0] addr_reg;
    logic [CW-1:0] chk_addr_reg;
    logic          chk_vld_reg;
    logic [7:0]    rd_data_reg;
    logic          found_reg;
    logic [11:0]   fpage_reg;
    logic          m_valid_reg;
    logic          ok_reg;
    logic          mfound_reg;
    logic [11:0]   mfpage_reg;
    logic          dirty_reg;

    logic [16:0]   spc_groups;
    logic [CW-1:0] scan_groups;
    logic          in_range;
    logic [AW-1:0] page_idx;
    logic [AW-1:0] raddr;
    logic          issue_vld;
    logic          any_free;
    logic [1:0]    free_lane;
    logic [7:0]    rmw_data;
    logic [1:0]    new_state;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          ok_next;
    logic [15:0]   count_next;
    logic [31:0]   fpage_wide;

    assign spc_groups  = {3'b000, spc_reg[15:2]};
    assign scan_groups = CW'((spc_groups > FULL_W) ? FULL_W : spc_groups);
    assign in_range    = {1'b0, page_reg} < PAGES_W;
    assign page_idx    = page_reg[2 +: AW];
    assign raddr       = cmd.scan_step ? addr_reg[AW-1:0] : page_idx;
    assign issue_vld   = addr_reg < scan_groups;

    // lowest free page of the group under check
    always_comb begin
        any_free  = 1'b0;
        free_lane = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (rd_data_reg[2*i +: 2] == PS_FREE) begin
                any_free  = 1'b1;
                free_lane = 2'(i);
            end
        end
    end

    assign new_state = (op_reg == OP_USE) ? PS_USED : PS_FREE;

    always_comb begin
        rmw_data = rd_data_reg;
        rmw_data[2*page_reg[1:0] +: 2] = new_state;
    end

    assign fpage_wide = 32'({chk_addr_reg, free_lane});

    // one write port: sweep, read-modify-write, or group load
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = page_idx;
        mem_wdata = grp_reg;
        if (cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg[AW-1:0];
            mem_wdata = GROUP_FREE;
        end else if (cmd.rmw_write) begin
            mem_we    = 1'b1;
            mem_wdata = rmw_data;
        end else if (cmd.post && op_reg == OP_LOAD && in_range) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb begin
        ok_next    = 1'b0;
        count_next = count_reg;
        case (op_reg)
            OP_FIND: begin
                ok_next = 1'b1;
            end
            OP_USE, OP_FREE: begin
                ok_next = in_range;
                if (in_range && count_reg != COUNT_TOP) begin
                    count_next = count_reg + 16'd1;
                end
            end
            OP_CLEAR: begin
                ok_next    = 1'b1;
                count_next = spc_reg;
            end
            OP_FLUSH: begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            OP_LOAD: begin
                ok_next = in_range;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= op_t'(s_operation);
            page_reg <= s_page;
            grp_reg  <= s_group_states;
        end
        if (cmd.scan_step) begin
            chk_addr_reg <= addr_reg;
        end
        if (cmd.addr_clear) begin
            found_reg <= 1'b0;
            fpage_reg <= '0;
        end else if (cmd.scan_step && chk_vld_reg && any_free) begin
            found_reg <= 1'b1;
            fpage_reg <= fpage_wide[11:0];
        end
        if (cmd.post) begin
            ok_reg     <= ok_next;
            mfound_reg <= (op_reg == OP_FIND) && found_reg;
            mfpage_reg <= (op_reg == OP_FIND) ? fpage_reg : 12'd0;
            dirty_reg  <= count_next != 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spc_reg     <= '0;
            count_reg   <= '0;
            addr_reg    <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                spc_reg <= cfg_wdata;
            end
            if (cmd.post) begin
                count_reg <= count_next;
            end
            if (cmd.addr_clear) begin
                addr_reg    <= '0;
                chk_vld_reg <= 1'b0;
            end else if (cmd.sweep_step) begin
                addr_reg <= addr_reg + CW'(1);
            end else if (cmd.scan_step) begin
                chk_vld_reg <= issue_vld;
                if (issue_vld) begin
                    addr_reg <= addr_reg + CW'(1);
                end
            end
            if (cmd.post) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.op         = op_reg;
        status.in_range   = in_range;
        status.sweep_last = addr_reg == LAST_G;
        status.scan_empty = scan_groups == '0;
        status.scan_hit   = chk_vld_reg && any_free;
        status.scan_end   = chk_vld_reg && (chk_addr_reg == scan_groups - CW'(1));
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_found       = mfound_reg;
    assign m_found_page  = mfpage_reg;
    assign m_table_dirty = dirty_reg;

endmodule

// File: hdl/flash_page_allocation_map_unit.sv
// After accept: dispatch, then find scans groups to a free page or range end, use/free
//   read and write back one group, clear all writes every group; output stalls delay the result.
// Throughput: one item at a time, next accept in the cycle after the result is posted;
//   a find reads one packed group per cycle and clear all writes one group per cycle.
// Reset: synchronous active-low, then a clearing pass marks every page free before the
//   first item is accepted; configuration writes are taken meanwhile.
module flash_page_allocation_map_unit import fpam_pkg::*; #(
    parameter int PAGES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [15:0] s_page,
    input  logic [7:0]  s_group_states,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_found,
    output logic [11:0] m_found_page,
    output logic        m_table_dirty
);

    cmd_t    cmd;
    status_t status;

    fpam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fpam_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_operation    (s_operation),
        .s_page         (s_page),
        .s_group_states (s_group_states),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_found        (m_found),
        .m_found_page   (m_found_page),
        .m_table_dirty  (m_table_dirty)
    );

endmodule
